// ----- rtl/core/kti_pkg.sv -----
// Package with shared types, codes and constants of the keyframe table interpolator.
package kti_pkg;

    // Default table depth.
    localparam int MAX_KEYS_DEF = 64;

    // Field widths.
    localparam int FRAME_W = 16;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int FRAC_W  = 16;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // One stored key.
    typedef struct packed {
        logic                       valid;
        logic        [FRAME_W-1:0]  frame;
        logic signed [VALUE_W-1:0]  x;
        logic signed [VALUE_W-1:0]  y;
        logic signed [VALUE_W-1:0]  z;
    } t_key;

    // Command broadcast to every cell.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_DOWN
    } t_cell_op;

    typedef struct packed {
        t_cell_op                   op;
        logic        [FRAME_W-1:0]  frame;
        t_key                       new_key;
    } t_cell_ctrl;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DELETE,
        S_SELECT,
        S_DIVIDE,
        S_MULT,
        S_SUM
    } t_state;

endpackage

// ----- rtl/core/kti_cell.sv -----
// One cell of the sorted key chain: holds a key and trades it with its neighbors.
module kti_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kti_pkg::t_cell_ctrl  i_ctrl,
    input  kti_pkg::t_key        i_left_key,   // lower neighbor, valid tied high for cell 0
    input  logic                 i_left_gt,    // lower neighbor frame above command frame
    input  kti_pkg::t_key        i_right_key,  // upper neighbor, invalid past the end
    output kti_pkg::t_key        o_key,
    output logic                 o_gt,
    output logic                 o_ge,
    output logic                 o_eq
);

    kti_pkg::t_key r_key;
    kti_pkg::t_key n_key;

    // Compares against the command frame.
    assign o_gt  = r_key.valid && (r_key.frame >  i_ctrl.frame);
    assign o_ge  = r_key.valid && (r_key.frame >= i_ctrl.frame);
    assign o_eq  = r_key.valid && (r_key.frame == i_ctrl.frame);
    assign o_key = r_key;

    // Insert moves keys above the new frame up one place; delete pulls the tail down.
    always_comb begin
        n_key = r_key;
        case (i_ctrl.op)
            kti_pkg::CELL_INSERT: begin
                if (o_gt || (!r_key.valid && i_left_key.valid)) begin
                    if (i_left_gt) begin
                        n_key = i_left_key;
                    end else begin
                        n_key = i_ctrl.new_key;
                    end
                    n_key.valid = 1'b1;
                end
            end
            kti_pkg::CELL_SHIFT_DOWN: begin
                if (o_ge) begin
                    n_key = i_right_key;
                end
            end
            default: begin
                n_key = r_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.valid <= 1'b0;
        end else begin
            r_key.valid <= n_key.valid;
        end
        r_key.frame <= n_key.frame;
        r_key.x     <= n_key.x;
        r_key.y     <= n_key.y;
        r_key.z     <= n_key.z;
    end

endmodule

// ----- rtl/core/kti_div.sv -----
// Restoring divider that forms the Q0.16 interpolation weight one bit per cycle.
module kti_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [kti_pkg::FRAME_W-1:0]   i_num,  // below i_den
    input  logic [kti_pkg::FRAME_W-1:0]   i_den,
    output logic                          o_done,
    output logic [kti_pkg::FRAC_W-1:0]    o_quot
);

    localparam int STEP_W = $clog2(kti_pkg::FRAC_W + 1);

    logic                          r_busy;
    logic [STEP_W-1:0]             r_step;
    logic [kti_pkg::FRAME_W-1:0]   r_rem;
    logic [kti_pkg::FRAME_W-1:0]   r_den;
    logic [kti_pkg::FRAC_W-1:0]    r_quot;
    logic                          r_done;
    logic [kti_pkg::FRAME_W:0]     w_shift;
    logic                          w_take;

    // One quotient bit per step.
    assign w_shift = {r_rem, 1'b0};
    assign w_take  = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(kti_pkg::FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (w_take) begin
                r_rem <= kti_pkg::FRAME_W'(w_shift - {1'b0, r_den});
            end else begin
                r_rem <= w_shift[kti_pkg::FRAME_W-1:0];
            end
            r_quot <= {r_quot[kti_pkg::FRAC_W-2:0], w_take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/core/keyframe_table_interpolator.sv -----
// Top level of the keyframe table interpolator: cell chain, controller and blend datapath.
//
//  channel | direction | tuser          | tdata (low bit up)
//  s_axis  | in        | operation[1:0] | frame, value_x, value_y, value_z
//  m_axis  | out       | status[1:0]    | out_x, out_y, out_z, key_count, one zero pad bit
//
// Inserts, unused operations and queries on an empty table give a result in the cycle after accept.
// Queries answered without interpolation are resolved in the select state.
// Delete stays in the delete state while a matching key remains, removing one each time, then reports.
// An interpolating query runs select, 16 divider steps, handoff, multiply and sum in turn.
// Reset clears the key count and all cell valid bits.
// One item is in work at a time; s_axis_tready stays low until the result is taken.
module keyframe_table_interpolator #(
    parameter int MAX_KEYS = kti_pkg::MAX_KEYS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [111:0]   s_axis_tdata,   // frame, value_x, value_y, value_z
    input  logic [1:0]     s_axis_tuser,   // operation
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [103:0]   m_axis_tdata,   // out_x, out_y, out_z, key_count, pad
    output logic [1:0]     m_axis_tuser    // status
);

    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int FW    = kti_pkg::FRAME_W;
    localparam int VW    = kti_pkg::VALUE_W;

    kti_pkg::t_state      r_state;
    kti_pkg::t_state      n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [FW-1:0]        r_frame;
    logic                 r_del_any;
    logic                 n_del_any;

    logic                 r_ovalid;
    logic                 n_ovalid;
    logic [1:0]           r_status;
    logic [1:0]           n_status;
    logic signed [VW-1:0] r_ox, r_oy, r_oz;
    logic signed [VW-1:0] n_ox, n_oy, n_oz;

    kti_pkg::t_key        r_ka, r_kb;
    logic signed [VW+FW+1:0] r_px, r_py, r_pz;

    kti_pkg::t_cell_ctrl  w_ctrl;
    kti_pkg::t_key        w_key  [MAX_KEYS];
    logic                 w_gt   [MAX_KEYS];
    logic                 w_ge   [MAX_KEYS];
    logic                 w_eq   [MAX_KEYS];
    logic                 w_left [MAX_KEYS];
    logic                 w_accept;
    logic                 w_any_eq;
    kti_pkg::t_key        w_sel_a, w_sel_b;
    logic                 w_have, w_has_right;
    logic                 w_div_start, w_div_done;
    logic [kti_pkg::FRAC_W-1:0] w_t;

    assign s_axis_tready = (r_state == kti_pkg::S_IDLE) && !r_ovalid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Command to the chain; the incoming frame is used in the accept cycle.
    always_comb begin
        w_ctrl.op            = kti_pkg::CELL_HOLD;
        w_ctrl.frame         = (r_state == kti_pkg::S_IDLE) ? s_axis_tdata[15:0] : r_frame;
        w_ctrl.new_key.valid = 1'b1;
        w_ctrl.new_key.frame = s_axis_tdata[15:0];
        w_ctrl.new_key.x     = s_axis_tdata[47:16];
        w_ctrl.new_key.y     = s_axis_tdata[79:48];
        w_ctrl.new_key.z     = s_axis_tdata[111:80];
        if (w_accept && s_axis_tuser == kti_pkg::OP_INSERT && r_count < CNT_W'(MAX_KEYS)) begin
            w_ctrl.op = kti_pkg::CELL_INSERT;
        end else if (r_state == kti_pkg::S_DELETE && w_any_eq) begin
            w_ctrl.op = kti_pkg::CELL_SHIFT_DOWN;
        end
    end

    // Chain of key cells.
    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
        kti_pkg::t_key w_lk, w_rk;
        logic          w_lgt;
        if (g == 0) begin : g_first
            always_comb begin
                w_lk       = '0;
                w_lk.valid = 1'b1;
                w_lgt      = 1'b0;
            end
        end else begin : g_mid
            assign w_lk  = w_key[g-1];
            assign w_lgt = w_gt[g-1];
        end
        if (g == MAX_KEYS - 1) begin : g_last
            assign w_rk = '0;
        end else begin : g_up
            assign w_rk = w_key[g+1];
        end
        kti_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_left_key  (w_lk),
            .i_left_gt   (w_lgt),
            .i_right_key (w_rk),
            .o_key       (w_key[g]),
            .o_gt        (w_gt[g]),
            .o_ge        (w_ge[g]),
            .o_eq        (w_eq[g])
        );
    end

    // Left key: the first exact match, else the last key below the query frame.
    always_comb begin
        logic next_lt, next_eq, prev_ge, lt;
        w_any_eq    = 1'b0;
        w_have      = 1'b0;
        w_has_right = 1'b0;
        w_sel_a     = '0;
        w_sel_b     = '0;
        for (int i = 0; i < MAX_KEYS; i++) begin
            lt      = w_key[i].valid && !w_ge[i];
            next_lt = (i < MAX_KEYS - 1) ? (w_key[(i+1)%MAX_KEYS].valid
                                            && !w_ge[(i+1)%MAX_KEYS]) : 1'b0;
            next_eq = (i < MAX_KEYS - 1) ? w_eq[(i+1)%MAX_KEYS] : 1'b0;
            prev_ge = (i > 0) ? w_ge[(i+MAX_KEYS-1)%MAX_KEYS] : 1'b0;
            w_left[i] = (w_eq[i] && !prev_ge) || (lt && !next_lt && !next_eq);
            w_any_eq  = w_any_eq | w_eq[i];
        end
        for (int i = 0; i < MAX_KEYS; i++) begin
            if (w_left[i]) begin
                w_have  = 1'b1;
                w_sel_a = w_sel_a | w_key[i];
            end
            if (i > 0 && w_left[(i+MAX_KEYS-1)%MAX_KEYS] && w_key[i].valid) begin
                w_has_right = 1'b1;
                w_sel_b     = w_sel_b | w_key[i];
            end
        end
    end

    assign w_div_start = (r_state == kti_pkg::S_SELECT) && w_have && w_has_right
                         && (w_sel_a.frame != w_sel_b.frame);

    kti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (FW'(r_frame - w_sel_a.frame)),
        .i_den   (FW'(w_sel_b.frame - w_sel_a.frame)),
        .o_done  (w_div_done),
        .o_quot  (w_t)
    );

    // Controller.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_del_any = r_del_any;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_status  = r_status;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_oz      = r_oz;
        unique case (r_state)
            kti_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_ox      = '0;
                    n_oy      = '0;
                    n_oz      = '0;
                    n_del_any = 1'b0;
                    n_status  = kti_pkg::ST_NONE;
                    if (s_axis_tuser == kti_pkg::OP_INSERT) begin
                        n_ovalid = 1'b1;
                        if (r_count < CNT_W'(MAX_KEYS)) begin
                            n_count  = r_count + 1'b1;
                            n_status = kti_pkg::ST_DONE;
                        end else begin
                            n_status = kti_pkg::ST_FULL;
                        end
                    end else if (s_axis_tuser == kti_pkg::OP_DELETE) begin
                        n_state = kti_pkg::S_DELETE;
                    end else if (s_axis_tuser == kti_pkg::OP_QUERY && r_count != '0) begin
                        n_state = kti_pkg::S_SELECT;
                    end else begin
                        n_ovalid = 1'b1;
                    end
                end
            end
            kti_pkg::S_DELETE: begin
                if (w_any_eq) begin
                    n_count   = r_count - 1'b1;
                    n_del_any = 1'b1;
                end else begin
                    n_status = r_del_any ? kti_pkg::ST_DONE : kti_pkg::ST_NONE;
                    n_ovalid = 1'b1;
                    n_state  = kti_pkg::S_IDLE;
                end
            end
            kti_pkg::S_SELECT: begin
                if (w_div_start) begin
                    n_state = kti_pkg::S_DIVIDE;
                end else begin
                    n_state  = kti_pkg::S_IDLE;
                    n_ovalid = 1'b1;
                    if (w_have && (w_has_right || w_sel_a.frame == r_frame)) begin
                        n_status = kti_pkg::ST_DONE;
                        n_ox     = w_sel_a.x;
                        n_oy     = w_sel_a.y;
                        n_oz     = w_sel_a.z;
                    end
                end
            end
            kti_pkg::S_DIVIDE: begin
                if (w_div_done) begin
                    n_state = kti_pkg::S_MULT;
                end
            end
            kti_pkg::S_MULT: begin
                n_state = kti_pkg::S_SUM;
            end
            kti_pkg::S_SUM: begin
                n_state  = kti_pkg::S_IDLE;
                n_ovalid = 1'b1;
                n_status = kti_pkg::ST_DONE;
                n_ox     = VW'($signed({r_ka.x[VW-1], r_ka.x}) + (r_px >>> kti_pkg::FRAC_W));
                n_oy     = VW'($signed({r_ka.y[VW-1], r_ka.y}) + (r_py >>> kti_pkg::FRAC_W));
                n_oz     = VW'($signed({r_ka.z[VW-1], r_ka.z}) + (r_pz >>> kti_pkg::FRAC_W));
            end
            default: begin
                n_state = kti_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kti_pkg::S_IDLE;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
            r_del_any <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovalid  <= n_ovalid;
            r_del_any <= n_del_any;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_oz     <= n_oz;
        if (w_accept) begin
            r_frame <= s_axis_tdata[15:0];
        end
        if (r_state == kti_pkg::S_SELECT) begin
            r_ka <= w_sel_a;
            r_kb <= w_sel_b;
        end
    end

    // Blend products: (b - a) * t, one multiplier per component.
    always_ff @(posedge i_clk) begin
        if (r_state == kti_pkg::S_MULT) begin
            r_px <= ($signed({r_kb.x[VW-1], r_kb.x}) - $signed({r_ka.x[VW-1], r_ka.x}))
                    * $signed({1'b0, w_t});
            r_py <= ($signed({r_kb.y[VW-1], r_kb.y}) - $signed({r_ka.y[VW-1], r_ka.y}))
                    * $signed({1'b0, w_t});
            r_pz <= ($signed({r_kb.z[VW-1], r_kb.z}) - $signed({r_ka.z[VW-1], r_ka.z}))
                    * $signed({1'b0, w_t});
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {1'b0, kti_pkg::COUNT_W'(r_count), r_oz, r_oy, r_ox};

endmodule
